// ===== rtl/second_order_allpass_filter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the second-order allpass filter unit.
// Both macros expect clk and rst_n in the scope where they are used.
// ----------------------------------------------------------------------------
`ifndef SECOND_ORDER_ALLPASS_FILTER_UNIT_ASSERT_SVH
`define SECOND_ORDER_ALLPASS_FILTER_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SOPAF_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SOPAF_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/sopaf_pkg.sv =====
// ----------------------------------------------------------------------------
// sopaf_pkg
// Widths, history record and register codes shared by the allpass filter.
// ----------------------------------------------------------------------------
`default_nettype none

package sopaf_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int CH_W       = 3;
    localparam int COEF_W     = 18;
    localparam int DIFF_W     = SAMPLE_W + 1;
    localparam int PROD_W     = COEF_W + DIFF_W;
    localparam int ACC_W      = PROD_W + 2;
    localparam int FRAC_SHIFT = 16;
    localparam int CFG_IDX_W  = 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic [CH_W-1:0]            chan_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COEF_ONE = 1'b0,
        CFG_COEF_TWO = 1'b1
    } cfg_idx_t;

    // One channel's delay lines: x1/y1 are the most recent input/output.
    typedef struct packed {
        sample_t x1;
        sample_t x2;
        sample_t x3;
        sample_t x4;
        sample_t y1;
        sample_t y2;
        sample_t y3;
        sample_t y4;
    } hist_t;

    // A candidate history entry that is still in flight.
    typedef struct packed {
        logic  live;
        chan_t ch;
        hist_t hist;
    } fwd_src_t;

endpackage

`default_nettype wire

// ===== rtl/sopaf_cfg_if.sv =====
// ----------------------------------------------------------------------------
// sopaf_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface sopaf_cfg_if import sopaf_pkg::*; ();

    logic     valid;
    logic     ready;
    cfg_idx_t index;
    coef_t    data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);

endinterface

`default_nettype wire

// ===== rtl/sopaf_in_if.sv =====
// ----------------------------------------------------------------------------
// sopaf_in_if
// Input sample channel: one sample and its channel number per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sopaf_in_if import sopaf_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t sample_in;
    chan_t   channel_in;

    modport source (output valid, output sample_in, output channel_in, input ready);
    modport sink   (input valid, input sample_in, input channel_in, output ready);

endinterface

`default_nettype wire

// ===== rtl/sopaf_out_if.sv =====
// ----------------------------------------------------------------------------
// sopaf_out_if
// Result channel: one filtered sample and its channel number per word.
// ----------------------------------------------------------------------------
`default_nettype none

interface sopaf_out_if import sopaf_pkg::*; ();

    logic    valid;
    logic    ready;
    sample_t sample_out;
    chan_t   channel_out;

    modport source (output valid, output sample_out, output channel_out, input ready);
    modport sink   (input valid, input sample_out, input channel_out, output ready);

endinterface

`default_nettype wire

// ===== rtl/sopaf_hist_mem.sv =====
// ----------------------------------------------------------------------------
// sopaf_hist_mem
// Per-channel history memory, one read and one write port, registered read.
// Entries never written since reset read as zero through per-entry valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sopaf_hist_mem import sopaf_pkg::*; #(
    parameter int DEPTH  = 8,
    parameter int ADDR_W = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              ren,
    input  logic [ADDR_W-1:0] raddr,
    output hist_t             rdata,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  hist_t             wdata
);

    hist_t mem_reg [DEPTH];
    logic  vld_reg [DEPTH];
    hist_t rd_data_reg;
    logic  rd_vld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (ren)
        begin
            rd_data_reg <= mem_reg[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (ren)
            begin
                rd_vld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

// ===== rtl/sopaf_fwd.sv =====
// ----------------------------------------------------------------------------
// sopaf_fwd
// Picks the newest copy of a channel's history: the entry about to be
// written, the entry written at the edge of the memory read, or memory data.
// ----------------------------------------------------------------------------
`default_nettype none

module sopaf_fwd import sopaf_pkg::*; (
    input  chan_t    ch,
    input  hist_t    mem_hist,
    input  fwd_src_t late_src,
    input  fwd_src_t wb_src,
    output hist_t    hist
);

    logic late_hit;
    logic wb_hit;

    assign late_hit = late_src.live && (late_src.ch == ch);
    assign wb_hit   = wb_src.live && (wb_src.ch == ch);

    always_comb
    begin
        if (late_hit)
        begin
            hist = late_src.hist;
        end
        else if (wb_hit)
        begin
            hist = wb_src.hist;
        end
        else
        begin
            hist = mem_hist;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sopaf_round_sat.sv =====
// ----------------------------------------------------------------------------
// sopaf_round_sat
// Final sum of the two products and the aligned fourth past input, rounded
// to nearest (ties upward) and saturated to the sample range.
// ----------------------------------------------------------------------------
`default_nettype none

module sopaf_round_sat import sopaf_pkg::*; (
    input  prod_t   prod_one,
    input  prod_t   prod_two,
    input  sample_t x_four,
    output sample_t y
);

    localparam int SCALED_W = ACC_W - FRAC_SHIFT;
    localparam int SAT_HI   = 2 ** (SAMPLE_W - 1) - 1;
    localparam int SAT_LO   = -(2 ** (SAMPLE_W - 1));
    localparam int BIAS     = 2 ** (FRAC_SHIFT - 1);

    logic signed [ACC_W-1:0]    acc;
    logic signed [SCALED_W-1:0] scaled;

    assign acc = ACC_W'(prod_one) + ACC_W'(prod_two)
               + (ACC_W'(x_four) <<< FRAC_SHIFT) + ACC_W'(BIAS);

    // Dropping the low bits of a two's complement value is a floor.
    assign scaled = acc[ACC_W-1:FRAC_SHIFT];

    always_comb
    begin
        if (scaled > SCALED_W'(SAT_HI))
        begin
            y = SAMPLE_W'(SAT_HI);
        end
        else if (scaled < SCALED_W'(SAT_LO))
        begin
            y = SAMPLE_W'(SAT_LO);
        end
        else
        begin
            y = scaled[SAMPLE_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/second_order_allpass_filter_unit.sv =====
// ----------------------------------------------------------------------------
// second_order_allpass_filter_unit
// Multichannel second-order allpass filter in delayed form; channel history
// is kept in one memory and updated by read, modify and write back.
// ----------------------------------------------------------------------------
//  channel       role    word                              accepted when
//  cfg           sink    index, data (coefficient)         valid && ready
//  sample_chan   sink    sample_in, channel_in             valid && ready
//  result_chan   source  sample_out, channel_out           valid && ready
//
//  One sample per cycle while no result word waits; a result word is
//  registered after its sample has passed stages s1, s2 and s3.
//  The memory read is issued from stage s1 after acceptance; the multipliers and
//  the round/saturate stage follow, and write-back coincides with the result.
//  History of an in-flight sample of the same channel is forwarded.
//  Reset clears history through per-channel valid bits; no clearing pass.
//  When a result word waits, the whole pipeline and sample_chan.ready hold.
// ----------------------------------------------------------------------------
`default_nettype none

`include "second_order_allpass_filter_unit_assert.svh"

module second_order_allpass_filter_unit import sopaf_pkg::*; #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    sopaf_cfg_if.sink   cfg,
    sopaf_in_if.sink    sample_chan,
    sopaf_out_if.source result_chan
);

    localparam int ADDR_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic    advance;
    coef_t   coef_one_reg;
    coef_t   coef_two_reg;

    logic    s1_valid_reg;
    sample_t s1_x_reg;
    chan_t   s1_ch_reg;
    logic    s1_ok_reg;

    logic    s2_valid_reg;
    sample_t s2_x_reg;
    chan_t   s2_ch_reg;
    logic    s2_ok_reg;

    logic    s3_valid_reg;
    chan_t   s3_ch_reg;
    logic    s3_ok_reg;
    prod_t   s3_p1_reg;
    prod_t   s3_p2_reg;
    sample_t s3_x4_reg;
    hist_t   s3_hist_reg;

    logic    out_valid_reg;
    sample_t out_sample_reg;
    chan_t   out_ch_reg;

    logic    wb_valid_reg;
    chan_t   wb_ch_reg;
    hist_t   wb_hist_reg;

    hist_t   mem_hist;
    hist_t   s2_hist;
    hist_t   s3_hist_next;
    hist_t   s3_entry;
    fwd_src_t late_src;
    fwd_src_t wb_src;
    logic signed [DIFF_W-1:0] d_one;
    logic signed [DIFF_W-1:0] d_two;
    prod_t   p1_next;
    prod_t   p2_next;
    sample_t y_s3;
    logic    mem_we;

    assign advance           = !out_valid_reg || result_chan.ready;
    assign sample_chan.ready = advance;
    assign cfg.ready         = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_one_reg <= '0;
            coef_two_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_COEF_ONE: coef_one_reg <= cfg.data;
                CFG_COEF_TWO: coef_two_reg <= cfg.data;
                default:      coef_one_reg <= coef_one_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            wb_valid_reg  <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= sample_chan.valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
            wb_valid_reg  <= s3_valid_reg && s3_ok_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_x_reg       <= sample_chan.sample_in;
            s1_ch_reg      <= sample_chan.channel_in;
            s1_ok_reg      <= 32'(sample_chan.channel_in) < NUM_CHANNELS;
            s2_x_reg       <= s1_x_reg;
            s2_ch_reg      <= s1_ch_reg;
            s2_ok_reg      <= s1_ok_reg;
            s3_ch_reg      <= s2_ch_reg;
            s3_ok_reg      <= s2_ok_reg;
            s3_p1_reg      <= p1_next;
            s3_p2_reg      <= p2_next;
            s3_x4_reg      <= s2_hist.x4;
            s3_hist_reg    <= s3_hist_next;
            out_sample_reg <= s3_ok_reg ? y_s3 : '0;
            out_ch_reg     <= s3_ch_reg;
            wb_ch_reg      <= s3_ch_reg;
            wb_hist_reg    <= s3_entry;
        end
    end

    assign mem_we = advance && s3_valid_reg && s3_ok_reg;

    sopaf_hist_mem #(
        .DEPTH  (NUM_CHANNELS),
        .ADDR_W (ADDR_W)
    ) u_hist_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .ren   (advance),
        .raddr (ADDR_W'(s1_ch_reg)),
        .rdata (mem_hist),
        .we    (mem_we),
        .waddr (ADDR_W'(s3_ch_reg)),
        .wdata (s3_entry)
    );

    // The entry in the last stage gets its newest output once it is rounded.
    always_comb
    begin
        s3_entry    = s3_hist_reg;
        s3_entry.y1 = y_s3;
    end

    // The memory read missed both the entry being finished and the one
    // written at the same edge as the read.
    assign late_src = '{live: s3_valid_reg && s3_ok_reg, ch: s3_ch_reg, hist: s3_entry};
    assign wb_src   = '{live: wb_valid_reg, ch: wb_ch_reg, hist: wb_hist_reg};

    sopaf_fwd u_fwd (
        .ch       (s2_ch_reg),
        .mem_hist (mem_hist),
        .late_src (late_src),
        .wb_src   (wb_src),
        .hist     (s2_hist)
    );

    assign d_one   = DIFF_W'(s2_hist.x2) - DIFF_W'(s2_hist.y2);
    assign d_two   = DIFF_W'(s2_x_reg) - DIFF_W'(s2_hist.y4);
    assign p1_next = PROD_W'(coef_one_reg) * PROD_W'(d_one);
    assign p2_next = PROD_W'(coef_two_reg) * PROD_W'(d_two);

    always_comb
    begin
        s3_hist_next.x1 = s2_x_reg;
        s3_hist_next.x2 = s2_hist.x1;
        s3_hist_next.x3 = s2_hist.x2;
        s3_hist_next.x4 = s2_hist.x3;
        s3_hist_next.y1 = '0;
        s3_hist_next.y2 = s2_hist.y1;
        s3_hist_next.y3 = s2_hist.y2;
        s3_hist_next.y4 = s2_hist.y3;
    end

    sopaf_round_sat u_round_sat (
        .prod_one (s3_p1_reg),
        .prod_two (s3_p2_reg),
        .x_four   (s3_x4_reg),
        .y        (y_s3)
    );

    assign result_chan.valid       = out_valid_reg;
    assign result_chan.sample_out  = out_sample_reg;
    assign result_chan.channel_out = out_ch_reg;

    `SOPAF_ASSERT_NEXT(a_accept_enters, sample_chan.valid && sample_chan.ready, s1_valid_reg, "accepted word did not enter the pipeline")
    `SOPAF_ASSERT_NEXT(a_last_stage_out, advance && s3_valid_reg, out_valid_reg && (out_ch_reg == $past(s3_ch_reg)), "finished word was not presented")
    `SOPAF_ASSERT_SAME(a_bad_chan_zero, result_chan.valid && (32'(result_chan.channel_out) >= NUM_CHANNELS), result_chan.sample_out == '0, "unknown channel gave a nonzero sample")
    `SOPAF_ASSERT_NEXT(a_write_tracked, mem_we, wb_valid_reg && (wb_ch_reg == $past(s3_ch_reg)), "write-back entry not kept for forwarding")

endmodule

`default_nettype wire
